### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define LLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define LLS_ASSERT_IMPL(label, ante, cons, msg) \
  `LLS_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define LLS_ASSERT_NEXT(label, ante, cons, msg) \
  `LLS_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// Types, codes and constants of the link liveness supervisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lls_pkg;

  // event kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // health grades
  localparam logic [1:0] H_HEALTHY     = 2'd0;
  localparam logic [1:0] H_DEGRADED    = 2'd1;
  localparam logic [1:0] H_INTERRUPTED = 2'd2;
  localparam logic [1:0] H_DEAD        = 2'd3;

  // teardown reasons
  localparam logic [1:0] TD_NONE     = 2'd0;
  localparam logic [1:0] TD_LOST     = 2'd1;
  localparam logic [1:0] TD_PROGRESS = 2'd2;

  // register map
  localparam int          CFG_COUNT   = 8;
  localparam int          CFG_INDEX_W = $clog2(CFG_COUNT);
  localparam logic [CFG_INDEX_W-1:0] REG_DEGRADED     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INTERRUPTED  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD         = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_PROG_WARN    = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_PROG_DEAD    = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_HB_GATE      = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_HB_INTERVAL  = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_GRACE = CFG_INDEX_W'(7);

  // register reset values, ms
  localparam logic [31:0] RST_DEGRADED      = 32'd1000;
  localparam logic [31:0] RST_INTERRUPTED   = 32'd5000;
  localparam logic [31:0] RST_DEAD          = 32'd20000;
  localparam logic [31:0] RST_PROG_WARN     = 32'd8000;
  localparam logic [31:0] RST_PROG_DEAD     = 32'd20000;
  localparam logic [31:0] RST_HB_GATE       = 32'd500;
  localparam logic [31:0] RST_HB_INTERVAL   = 32'd250;
  localparam logic [31:0] RST_STARTUP_GRACE = 32'd1000;

  // x / 1000 == (x * ceil(2^38 / 1000)) >> 38, exact for all 32 bit x
  localparam int          DIV_IN_W   = 32;
  localparam int          DIV_MAG_W  = 29;
  localparam int          DIV_SHIFT  = 38;
  localparam int          DIV_PROD_W = DIV_IN_W + DIV_MAG_W;
  localparam logic [DIV_MAG_W-1:0] DIV1000_MAGIC = 29'd274877907;
  localparam int          SECS_W     = 23;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic [31:0]        silence_ms;
    logic               link_live;
    logic               sim_running;
    logic               suspended;
    logic signed [31:0] current_frame;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        health;
    logic              peer_alive;
    logic [31:0]       silence_view;
    logic [31:0]       stall_view;
    logic              stall_warned;
    logic              heartbeat_send;
    logic [31:0]       heartbeat_id;
    logic [1:0]        teardown;
    logic [SECS_W-1:0] teardown_seconds;
  } out_word_t;

  // result before the seconds conversion
  typedef struct packed {
    logic [1:0]  health;
    logic        peer_alive;
    logic [31:0] silence_view;
    logic [31:0] stall_view;
    logic        stall_warned;
    logic        heartbeat_send;
    logic [31:0] heartbeat_id;
    logic [1:0]  teardown;
    logic [31:0] dividend;
  } mid_word_t;

endpackage

### rtl/link_liveness_supervisor.sv
// ----------------------------------------------------------------------------
// link_liveness_supervisor
// Grades peer silence, paces heartbeats and watches frame progress per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_word is one event word (tick, start or end), taken when in_valid is
//   high and in_stall low. out_word carries exactly one result word per
//   event, taken when out_valid is high and out_stall low.
//   cfg_we/cfg_index/cfg_wdata write the eight threshold registers; write
//   only while no event is in flight. Zero writes to the three silence
//   thresholds are dropped.
//   The word passes the input register, the state update stage and the seconds
//   conversion stage in turn before out_valid rises. Throughput: one word per
//   cycle while out_stall is low.
//   The state update is a single compare-and-select pass; the seconds figure
//   is a reciprocal multiply in the last stage.
//   Reset (rst_n low at a clock edge) empties the pipe, returns supervision
//   state to idle and the registers to their defaults.
//   While out_stall is high, words queue in the three stages; in_stall rises
//   only once all three are full and the output is still stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_liveness_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  // event channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lls_pkg::in_word_t                in_word,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output lls_pkg::out_word_t               out_word,
  // register write port
  input  logic                             cfg_we,
  input  logic [lls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  import lls_pkg::*;

`include "assert_macros.svh"

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] degraded_r, interrupted_r, dead_r, prog_warn_r, prog_dead_r;
  logic [31:0] hb_gate_r, hb_interval_r, grace_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degraded_r    <= RST_DEGRADED;
      interrupted_r <= RST_INTERRUPTED;
      dead_r        <= RST_DEAD;
      prog_warn_r   <= RST_PROG_WARN;
      prog_dead_r   <= RST_PROG_DEAD;
      hb_gate_r     <= RST_HB_GATE;
      hb_interval_r <= RST_HB_INTERVAL;
      grace_r       <= RST_STARTUP_GRACE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGRADED:      if (cfg_wdata != '0) degraded_r <= cfg_wdata;
        REG_INTERRUPTED:   if (cfg_wdata != '0) interrupted_r <= cfg_wdata;
        REG_DEAD:          if (cfg_wdata != '0) dead_r <= cfg_wdata;
        REG_PROG_WARN:     prog_warn_r <= cfg_wdata;
        REG_PROG_DEAD:     prog_dead_r <= cfg_wdata;
        REG_HB_GATE:       hb_gate_r <= cfg_wdata;
        REG_HB_INTERVAL:   hb_interval_r <= cfg_wdata;
        REG_STARTUP_GRACE: grace_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control: input register -> update stage -> output register
  // --------------------------------------------------------------------------
  logic      in_valid_r, mid_valid_r, out_valid_r;
  in_word_t  in_r;
  mid_word_t mid_r, mid_nxt;
  out_word_t out_r;

  logic out_load;   // output register can take a word
  logic mid_ready;  // update stage can take a word
  logic mid_move;   // update stage word moves to output
  logic s1_fire;    // event is processed and state updated
  logic in_ready;

  assign out_load  = !out_valid_r || !out_stall;
  assign mid_move  = mid_valid_r && out_load;
  assign mid_ready = !mid_valid_r || out_load;
  assign s1_fire   = in_valid_r && mid_ready;
  assign in_ready  = !in_valid_r || mid_ready;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)  in_valid_r  <= in_valid;
      if (mid_ready) mid_valid_r <= in_valid_r;
      if (out_load)  out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_word;
    if (s1_fire) mid_r <= mid_nxt;
  end

  // --------------------------------------------------------------------------
  // Supervision state
  // --------------------------------------------------------------------------
  logic        sup_r, sup_nxt;
  logic        dead_rep_r, dead_rep_nxt;
  logic [1:0]  health_r, health_nxt;
  logic [31:0] last_sil_r, last_sil_nxt;
  logic [31:0] last_hb_r, last_hb_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] ping_r, ping_nxt;
  logic [31:0] anchor_frame_r, anchor_frame_nxt;
  logic [31:0] anchor_time_r, anchor_time_nxt;
  logic        warned_r, warned_nxt;
  logic        fired_r, fired_nxt;
  logic [31:0] stall_r, stall_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r          <= 1'b0;
      dead_rep_r     <= 1'b0;
      health_r       <= H_HEALTHY;
      last_sil_r     <= '0;
      last_hb_r      <= '0;
      start_r        <= '0;
      ping_r         <= '0;
      anchor_frame_r <= '1;
      anchor_time_r  <= '0;
      warned_r       <= 1'b0;
      fired_r        <= 1'b0;
      stall_r        <= '0;
    end else if (s1_fire) begin
      sup_r          <= sup_nxt;
      dead_rep_r     <= dead_rep_nxt;
      health_r       <= health_nxt;
      last_sil_r     <= last_sil_nxt;
      last_hb_r      <= last_hb_nxt;
      start_r        <= start_nxt;
      ping_r         <= ping_nxt;
      anchor_frame_r <= anchor_frame_nxt;
      anchor_time_r  <= anchor_time_nxt;
      warned_r       <= warned_nxt;
      fired_r        <= fired_nxt;
      stall_r        <= stall_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage: all compares run in parallel off the input register
  // --------------------------------------------------------------------------
  logic [31:0] now, sil, frame_raw;
  logic [31:0] grace_elapsed, hb_elapsed, stall_raw;
  logic        in_grace, hb_due;
  logic [1:0]  health_cls;

  assign now           = in_r.now_ms;
  assign sil           = in_r.silence_ms;
  assign frame_raw     = in_r.current_frame;
  assign grace_elapsed = now - start_r;
  assign hb_elapsed    = now - last_hb_r;
  assign stall_raw     = (now >= anchor_time_r) ? (now - anchor_time_r) : '0;
  assign in_grace      = (start_r != '0) && (grace_elapsed < grace_r);
  assign hb_due        = (last_hb_r == '0) || (hb_elapsed >= hb_interval_r);

  always_comb begin
    priority if (sil >= dead_r)        health_cls = H_DEAD;
    else if (sil >= interrupted_r)     health_cls = H_INTERRUPTED;
    else if (sil >= degraded_r)        health_cls = H_DEGRADED;
    else                               health_cls = H_HEALTHY;
  end

  always_comb begin
    logic [1:0]  tear;
    logic [31:0] div;
    logic        hb_send;
    logic [31:0] hb_id;
    logic [1:0]  h;

    sup_nxt          = sup_r;
    dead_rep_nxt     = dead_rep_r;
    health_nxt       = health_r;
    last_sil_nxt     = last_sil_r;
    last_hb_nxt      = last_hb_r;
    start_nxt        = start_r;
    ping_nxt         = ping_r;
    anchor_frame_nxt = anchor_frame_r;
    anchor_time_nxt  = anchor_time_r;
    warned_nxt       = warned_r;
    fired_nxt        = fired_r;
    stall_nxt        = stall_r;
    tear             = TD_NONE;
    div              = '0;
    hb_send          = 1'b0;
    hb_id            = '0;

    unique case (in_r.kind)
      KIND_START: begin
        // restart keeps the ping counter
        sup_nxt          = 1'b1;
        dead_rep_nxt     = 1'b0;
        health_nxt       = H_HEALTHY;
        last_sil_nxt     = '0;
        last_hb_nxt      = '0;
        start_nxt        = now;
        fired_nxt        = 1'b0;
        anchor_frame_nxt = '1;
        anchor_time_nxt  = '0;
        warned_nxt       = 1'b0;
        stall_nxt        = '0;
      end
      KIND_END: begin
        if (sup_r) begin
          sup_nxt          = 1'b0;
          health_nxt       = H_HEALTHY;
          dead_rep_nxt     = 1'b0;
          fired_nxt        = 1'b0;
          anchor_frame_nxt = '1;
          anchor_time_nxt  = '0;
          warned_nxt       = 1'b0;
          stall_nxt        = '0;
        end
      end
      KIND_TICK: begin
        if (sup_r && in_r.link_live) begin
          last_sil_nxt = sil;
          if (!in_grace) begin
            health_nxt = health_cls;
            // heartbeat pacing
            if (sil >= hb_gate_r) begin
              if (hb_due) begin
                last_hb_nxt = now;
                ping_nxt    = ping_r + 32'd1;
                hb_send     = 1'b1;
                hb_id       = ping_r + 32'd1;
              end
            end else begin
              last_hb_nxt = '0;
            end
            // dead teardown wins; watchdog skipped on that tick
            if (health_cls == H_DEAD && !dead_rep_r) begin
              dead_rep_nxt = 1'b1;
              tear         = TD_LOST;
              div          = sil;
            end else if (!fired_r) begin
              if (!in_r.sim_running || sil >= interrupted_r || in_r.suspended) begin
                anchor_frame_nxt = '1;
                anchor_time_nxt  = '0;
                warned_nxt       = 1'b0;
                stall_nxt        = '0;
              end else if (frame_raw != anchor_frame_r || anchor_time_r == '0) begin
                anchor_frame_nxt = frame_raw;
                anchor_time_nxt  = now;
                warned_nxt       = 1'b0;
                stall_nxt        = '0;
              end else begin
                stall_nxt = stall_raw;
                if (stall_raw >= prog_dead_r) begin
                  fired_nxt = 1'b1;
                  tear      = TD_PROGRESS;
                  div       = stall_raw;
                end else if (stall_raw >= prog_warn_r) begin
                  warned_nxt = 1'b1;
                end
              end
            end
          end
        end
      end
      default: ;  // unused kind code: state untouched
    endcase

    h = sup_nxt ? health_nxt : H_HEALTHY;
    mid_nxt.health         = h;
    mid_nxt.peer_alive     = (h == H_HEALTHY) || (h == H_DEGRADED);
    mid_nxt.silence_view   = sup_nxt ? last_sil_nxt : '0;
    mid_nxt.stall_view     = sup_nxt ? stall_nxt : '0;
    mid_nxt.stall_warned   = sup_nxt && warned_nxt;
    mid_nxt.heartbeat_send = hb_send;
    mid_nxt.heartbeat_id   = hb_id;
    mid_nxt.teardown       = tear;
    mid_nxt.dividend       = div;
  end

  // --------------------------------------------------------------------------
  // Output stage: ms to seconds by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [DIV_PROD_W-1:0] secs_prod;

  assign secs_prod = DIV_PROD_W'(mid_r.dividend) * DIV_PROD_W'(DIV1000_MAGIC);

  always_ff @(posedge clk) begin
    if (mid_move) begin
      out_r.health           <= mid_r.health;
      out_r.peer_alive       <= mid_r.peer_alive;
      out_r.silence_view     <= mid_r.silence_view;
      out_r.stall_view       <= mid_r.stall_view;
      out_r.stall_warned     <= mid_r.stall_warned;
      out_r.heartbeat_send   <= mid_r.heartbeat_send;
      out_r.heartbeat_id     <= mid_r.heartbeat_id;
      out_r.teardown         <= mid_r.teardown;
      out_r.teardown_seconds <= secs_prod[DIV_SHIFT +: SECS_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LLS_ASSERT_IMPL(a_idle_healthy, !sup_r, health_r == H_HEALTHY, "idle but health not clear")
  `LLS_ASSERT_IMPL(a_empty_no_stall, !in_valid_r, !in_stall, "stall with empty input register")
  `LLS_ASSERT_NEXT(a_mid_hold, mid_valid_r && !out_load, mid_valid_r && $stable(mid_r), "update stage word lost")
  `LLS_ASSERT_NEXT(a_dead_once, s1_fire && mid_nxt.teardown == TD_LOST, dead_rep_r, "dead teardown not latched")

endmodule

### tb/link_liveness_supervisor_tb.sv
// ----------------------------------------------------------------------------
// link_liveness_supervisor_tb
// Self-checking bench: directed and random event words with random idling on
// both channels. Every result word is compared field by field against an
// in-bench prediction of the supervisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_liveness_supervisor_tb;
  import lls_pkg::*;

  // kind code that the block must treat as a no-op
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // {link_live, sim_running, suspended}
  localparam logic [2:0] FL_RUN  = 3'b110;
  localparam logic [2:0] FL_DOWN = 3'b010;
  localparam logic [2:0] FL_NOSIM = 3'b100;
  localparam logic [2:0] FL_SUSP = 3'b111;

  localparam int PIPE_SLACK   = 8;    // drain slack beyond the 3 stage pipe
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000; // cycles with no word moving
  localparam int PHASE_WORDS  = 230;
  localparam int PHASE_COUNT  = 8;
  localparam int MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the supervisor plus the queue of verdicts
  // still owed by the block.
  // --------------------------------------------------------------------------
  class liveness_scoreboard;
    logic [31:0] thresh [CFG_COUNT];
    bit          active, dead_told, warned, fired;
    logic [1:0]  grade;
    logic [31:0] last_sil, last_ping_ms, start_ms, ping_count;
    logic [31:0] anchor_frame, anchor_ms, stall_ms;
    out_word_t   owed_verdicts[$];
    int          mismatches;
    int          checked;

    function new();
      thresh[REG_DEGRADED]      = RST_DEGRADED;
      thresh[REG_INTERRUPTED]   = RST_INTERRUPTED;
      thresh[REG_DEAD]          = RST_DEAD;
      thresh[REG_PROG_WARN]     = RST_PROG_WARN;
      thresh[REG_PROG_DEAD]     = RST_PROG_DEAD;
      thresh[REG_HB_GATE]       = RST_HB_GATE;
      thresh[REG_HB_INTERVAL]   = RST_HB_INTERVAL;
      thresh[REG_STARTUP_GRACE] = RST_STARTUP_GRACE;
      active       = 1'b0;
      dead_told    = 1'b0;
      fired        = 1'b0;
      grade        = H_HEALTHY;
      last_sil     = '0;
      last_ping_ms = '0;
      start_ms     = '0;
      ping_count   = '0;
      mismatches   = 0;
      checked      = 0;
      clear_progress();
    endfunction

    function void clear_progress();
      anchor_frame = '1;
      anchor_ms    = '0;
      warned       = 1'b0;
      stall_ms     = '0;
    endfunction

    // zero is dropped for the three silence thresholds
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      if (val == '0 && (idx == REG_DEGRADED || idx == REG_INTERRUPTED || idx == REG_DEAD))
        return;
      thresh[idx] = val;
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    // advance the shadow state by one accepted event and queue its verdict
    function void predict_verdict(in_word_t w);
      out_word_t   v;
      logic [1:0]  shown;
      logic [1:0]  td;
      logic [31:0] td_ms, secs, elapsed, since_ping;
      bit          ping;
      ping = 1'b0;
      td   = TD_NONE;
      td_ms = '0;
      v    = '0;
      if (w.kind == KIND_START) begin
        // restart keeps the ping counter
        active       = 1'b1;
        dead_told    = 1'b0;
        grade        = H_HEALTHY;
        last_sil     = '0;
        last_ping_ms = '0;
        start_ms     = w.now_ms;
        fired        = 1'b0;
        clear_progress();
      end else if (w.kind == KIND_END) begin
        if (active) begin
          active    = 1'b0;
          grade     = H_HEALTHY;
          dead_told = 1'b0;
          fired     = 1'b0;
          clear_progress();
        end
      end else if (w.kind == KIND_TICK && active && w.link_live) begin
        last_sil   = w.silence_ms;
        elapsed    = w.now_ms - start_ms;
        since_ping = w.now_ms - last_ping_ms;
        // start time of zero means no grace at all
        if (start_ms == '0 || elapsed >= thresh[REG_STARTUP_GRACE]) begin
          if (w.silence_ms >= thresh[REG_DEAD])             grade = H_DEAD;
          else if (w.silence_ms >= thresh[REG_INTERRUPTED]) grade = H_INTERRUPTED;
          else if (w.silence_ms >= thresh[REG_DEGRADED])    grade = H_DEGRADED;
          else                                              grade = H_HEALTHY;

          if (w.silence_ms >= thresh[REG_HB_GATE]) begin
            // a ping stamped at time 0 looks like none at all
            if (last_ping_ms == '0 || since_ping >= thresh[REG_HB_INTERVAL]) begin
              last_ping_ms = w.now_ms;
              ping_count   = ping_count + 32'd1;
              ping         = 1'b1;
            end
          end else begin
            last_ping_ms = '0;
          end

          if (grade == H_DEAD && !dead_told) begin
            // dead teardown skips the progress watchdog on this tick
            dead_told = 1'b1;
            td        = TD_LOST;
            td_ms     = w.silence_ms;
          end else if (!fired) begin
            if (!w.sim_running || w.suspended ||
                w.silence_ms >= thresh[REG_INTERRUPTED]) begin
              clear_progress();
            end else if (w.current_frame != anchor_frame || anchor_ms == '0) begin
              anchor_frame = w.current_frame;
              anchor_ms    = w.now_ms;
              warned       = 1'b0;
              stall_ms     = '0;
            end else begin
              // clock behind the anchor reads as no stall
              stall_ms = (w.now_ms >= anchor_ms) ? w.now_ms - anchor_ms : '0;
              if (stall_ms >= thresh[REG_PROG_DEAD]) begin
                fired = 1'b1;
                td    = TD_PROGRESS;
                td_ms = stall_ms;
              end else if (stall_ms >= thresh[REG_PROG_WARN]) begin
                warned = 1'b1;
              end
            end
          end
        end
      end

      shown              = active ? grade : H_HEALTHY;
      secs               = td_ms / 32'd1000;
      v.health           = shown;
      v.peer_alive       = (shown == H_HEALTHY || shown == H_DEGRADED);
      v.silence_view     = active ? last_sil : '0;
      v.stall_view       = active ? stall_ms : '0;
      v.stall_warned     = active && warned;
      v.heartbeat_send   = ping;
      v.heartbeat_id     = ping ? ping_count : '0;
      v.teardown         = td;
      v.teardown_seconds = secs[SECS_W-1:0];
      owed_verdicts.push_back(v);
    endfunction

    function void note_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch on word %0d, %s: expected %0h, got %0h",
                   checked, name, want, got);
      end
    endfunction

    function void check_verdict(out_word_t got);
      out_word_t want;
      if (owed_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %0d: %0h", checked, got);
        checked++;
        return;
      end
      want = owed_verdicts.pop_front();
      note_field("health",           want.health,           got.health);
      note_field("peer_alive",       want.peer_alive,       got.peer_alive);
      note_field("silence_view",     want.silence_view,     got.silence_view);
      note_field("stall_view",       want.stall_view,       got.stall_view);
      note_field("stall_warned",     want.stall_warned,     got.stall_warned);
      note_field("heartbeat_send",   want.heartbeat_send,   got.heartbeat_send);
      note_field("heartbeat_id",     want.heartbeat_id,     got.heartbeat_id);
      note_field("teardown",         want.teardown,         got.teardown);
      note_field("teardown_seconds", want.teardown_seconds, got.teardown_seconds);
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its ports
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_word;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_wdata;

  liveness_scoreboard sb;
  logic [31:0]        ms_clock;  // running event time for random sessions
  bit                 calm_in;   // no gaps from the sender
  bit                 calm_out;  // no stalls from the receiver
  bit                 hold_req;  // ask the receiver for one long hold-off
  int                 quiet;

  link_liveness_supervisor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Both monitors in one process: a word going in and a word coming out at
  // the same edge belong to different events, so the order here is safe.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.predict_verdict(in_word);
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_word);
  end

  // Watchdog: resets its count whenever a word moves on either channel.
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall runs, mostly short, now and then long; one long
  // hold-off on request so the pipe fills and the input stalls.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int run;
    int r;
    bit stalling;
    out_stall = 1'b0;
    run       = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        run = 0;
      end
      if (run == 0) begin
        r        = $urandom_range(0, 99);
        stalling = ($urandom_range(0, 9) < 3);
        run      = (r < 85) ? $urandom_range(1, 4) : $urandom_range(15, 60);
      end
      run--;
      out_stall <= stalling && !calm_out;
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic in_word_t mk_event(logic [1:0] kind, logic [31:0] now,
                                        logic [31:0] sil, logic [2:0] flags,
                                        logic [31:0] frame);
    in_word_t w;
    w.kind          = kind;
    w.now_ms        = now;
    w.silence_ms    = sil;
    {w.link_live, w.sim_running, w.suspended} = flags;
    w.current_frame = frame;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow back to back.
  task automatic send_event(in_word_t w);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 60) gap = 0;
    else if (r < 90)       gap = $urandom_range(1, 3);
    else if (r < 97)       gap = $urandom_range(4, 12);
    else                   gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and let every owed word come back before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // Sessions: start, a run of ticks with thresholds-aware silence, wandering
  // time and a mostly frozen frame, then usually an end. A tenth is noise.
  task automatic random_traffic(int n);
    int          sent;
    int          len;
    int          tempo;
    logic [31:0] sil;
    logic [31:0] step;
    logic [31:0] frame;
    logic [2:0]  flags;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(mk_event(2'($urandom_range(0, 3)), $urandom, $urandom,
                            3'($urandom_range(0, 7)), $urandom));
        sent++;
      end else begin
        case ($urandom_range(0, 19))
          0:       ms_clock = '0;
          1:       ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
          default: ms_clock = ms_clock + 32'($urandom_range(0, 5000));
        endcase
        send_event(mk_event(KIND_START, ms_clock, $urandom,
                            3'($urandom_range(0, 7)), $urandom));
        sent++;
        len   = $urandom_range(4, 40);
        tempo = $urandom_range(20, 2500);
        frame = $urandom;
        repeat (len) begin
          case ($urandom_range(0, 19))
            0:       step = '0;
            1:       step = $urandom;  // wraps, may land behind the anchor
            2:       step = sb.thresh[REG_PROG_WARN];
            3:       step = sb.thresh[REG_PROG_DEAD];
            4:       step = sb.thresh[REG_HB_INTERVAL];
            default: step = $urandom_range(0, tempo);
          endcase
          ms_clock = ms_clock + step;
          case ($urandom_range(0, 11))
            0:       sil = '0;
            1:       sil = $urandom;
            2:       sil = 32'hFFFF_FFFF;
            3:       sil = sb.thresh[REG_HB_GATE] + 32'($urandom_range(0, 2)) - 32'd1;
            4:       sil = sb.thresh[REG_DEGRADED] + 32'($urandom_range(0, 2)) - 32'd1;
            5:       sil = sb.thresh[REG_INTERRUPTED] + 32'($urandom_range(0, 2)) - 32'd1;
            6:       sil = sb.thresh[REG_DEAD] + 32'($urandom_range(0, 2)) - 32'd1;
            7, 8:    sil = $urandom_range(0, sb.thresh[REG_DEGRADED]);
            default: sil = $urandom_range(0, sb.thresh[REG_DEAD]);
          endcase
          case ($urandom_range(0, 19)) inside
            [0:12]:  frame = frame;
            [13:17]: frame = frame + 32'd1;
            default: frame = $urandom;
          endcase
          flags = {($urandom_range(0, 9) != 0), ($urandom_range(0, 6) != 0),
                   ($urandom_range(0, 9) == 0)};
          send_event(mk_event(KIND_TICK, ms_clock, sil, flags, frame));
          sent++;
        end
        if ($urandom_range(0, 9) < 8) begin
          send_event(mk_event(KIND_END, ms_clock, $urandom,
                              3'($urandom_range(0, 7)), $urandom));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] vals [CFG_COUNT];
    logic [31:0] lo;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm_in   = 1'b0;
    calm_out  = 1'b0;
    hold_req  = 1'b0;
    ms_clock  = '0;
    sb        = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass on reset thresholds
    send_event(mk_event(KIND_UNKNOWN, $urandom, $urandom, FL_SUSP, $urandom));
    send_event(mk_event(KIND_END,   32'd5,  32'd0,    FL_RUN, 32'd0));   // end while idle
    send_event(mk_event(KIND_TICK,  32'd10, 32'd2000, FL_RUN, 32'd0));   // tick while idle
    send_event(mk_event(KIND_START, 32'd0,  32'd0,    FL_RUN, 32'd0));   // no grace
    send_event(mk_event(KIND_TICK,  32'd0,  32'd600,  FL_RUN, 32'd5));  // ping at time 0
    send_event(mk_event(KIND_TICK,  32'd0,  32'd600,  FL_RUN, 32'd5));  // and again
    send_event(mk_event(KIND_TICK,  32'd100, 32'd0,   FL_RUN, 32'd5));
    send_event(mk_event(KIND_TICK,  32'd50,  32'd0,   FL_RUN, 32'd5));  // behind anchor
    send_event(mk_event(KIND_TICK,  32'd200, 32'd30000, FL_DOWN, 32'd5)); // link down
    send_event(mk_event(KIND_TICK,  32'd9000, 32'd0,  FL_RUN, 32'd5));  // warning
    send_event(mk_event(KIND_TICK,  32'd20200, 32'd0, FL_RUN, 32'd5));  // progress teardown
    send_event(mk_event(KIND_TICK,  32'd20300, 32'hFFFF_FFFF, FL_RUN, 32'd5)); // dead
    send_event(mk_event(KIND_UNKNOWN, $urandom, $urandom, FL_RUN, $urandom));
    send_event(mk_event(KIND_TICK,  32'd20400, 32'd30000, FL_RUN, 32'd6));
    send_event(mk_event(KIND_START, 32'd30000, 32'd0, FL_RUN, 32'd6));  // restart
    send_event(mk_event(KIND_TICK,  32'd30500, 32'd25000, FL_RUN, 32'd6)); // in grace
    send_event(mk_event(KIND_TICK,  32'd31000, 32'd25000, FL_RUN, 32'd6));
    send_event(mk_event(KIND_START, 32'hFFFF_FF00, 32'd0, FL_RUN, 32'd0));
    send_event(mk_event(KIND_TICK,  32'h0000_0100, 32'd6000, FL_RUN, 32'd1)); // grace wraps
    send_event(mk_event(KIND_TICK,  32'h0000_0400, 32'd6000, FL_RUN, 32'h8000_0000));
    send_event(mk_event(KIND_TICK,  32'h0000_0500, 32'd100, FL_NOSIM, 32'h7FFF_FFFF));
    send_event(mk_event(KIND_TICK,  32'h0000_0600, 32'd100, FL_SUSP, 32'h7FFF_FFFF));
    send_event(mk_event(KIND_TICK,  32'h0000_0700, 32'd100, FL_RUN, 32'hFFFF_FFFF));
    send_event(mk_event(KIND_END,   32'h0000_0800, 32'd0, FL_RUN, 32'd0));

    random_traffic(PHASE_WORDS);

    for (int p = 1; p < PHASE_COUNT; p++) begin
      drain();
      case (p)
        1: begin
          vals[REG_DEGRADED]      = 32'd100;
          vals[REG_INTERRUPTED]   = 32'd300;
          vals[REG_DEAD]          = 32'd600;
          vals[REG_PROG_WARN]     = 32'd200;
          vals[REG_PROG_DEAD]     = 32'd500;
          vals[REG_HB_GATE]       = 32'd50;
          vals[REG_HB_INTERVAL]   = 32'd0;
          vals[REG_STARTUP_GRACE] = 32'd0;
        end
        2: begin
          // lowest legal thresholds, watchdog fires as soon as a frame repeats
          vals[REG_DEGRADED]      = 32'd1;
          vals[REG_INTERRUPTED]   = 32'd2;
          vals[REG_DEAD]          = 32'd3;
          vals[REG_PROG_WARN]     = 32'd0;
          vals[REG_PROG_DEAD]     = 32'd0;
          vals[REG_HB_GATE]       = 32'd0;
          vals[REG_HB_INTERVAL]   = 32'd0;
          vals[REG_STARTUP_GRACE] = 32'd0;
        end
        3: begin
          // zeros to the silence thresholds must be dropped
          vals[REG_DEGRADED]      = 32'd0;
          vals[REG_INTERRUPTED]   = 32'd0;
          vals[REG_DEAD]          = 32'd0;
          vals[REG_PROG_WARN]     = 32'hFFFF_FFFF;
          vals[REG_PROG_DEAD]     = 32'hFFFF_FFFF;
          vals[REG_HB_GATE]       = 32'hFFFF_FFFF;
          vals[REG_HB_INTERVAL]   = 32'hFFFF_FFFF;
          vals[REG_STARTUP_GRACE] = 32'd0;
        end
        4: begin
          vals[REG_DEGRADED]      = 32'hFFFF_FFFF;
          vals[REG_INTERRUPTED]   = 32'hFFFF_FFFF;
          vals[REG_DEAD]          = 32'hFFFF_FFFF;
          vals[REG_PROG_WARN]     = 32'd300;
          vals[REG_PROG_DEAD]     = 32'd1500;
          vals[REG_HB_GATE]       = 32'd1;
          vals[REG_HB_INTERVAL]   = 32'd1;
          vals[REG_STARTUP_GRACE] = 32'hFFFF_FFFF;
        end
        5: begin
          // ordered, moderate thresholds
          lo = $urandom_range(1, 1000);
          vals[REG_DEGRADED]      = lo;
          vals[REG_INTERRUPTED]   = lo + 32'($urandom_range(0, 2000));
          vals[REG_DEAD]          = vals[REG_INTERRUPTED] + 32'($urandom_range(0, 5000));
          vals[REG_PROG_WARN]     = $urandom_range(0, 3000);
          vals[REG_PROG_DEAD]     = $urandom_range(0, 6000);
          vals[REG_HB_GATE]       = $urandom_range(0, 1500);
          vals[REG_HB_INTERVAL]   = $urandom_range(0, 800);
          vals[REG_STARTUP_GRACE] = $urandom_range(0, 2000);
        end
        default: begin
          // unordered, a zero here and there
          for (int r = 0; r < CFG_COUNT; r++)
            vals[r] = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 4000));
        end
      endcase
      for (int r = 0; r < CFG_COUNT; r++) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_W'(r);
        cfg_wdata <= vals[r];
        sb.write_reg(CFG_INDEX_W'(r), vals[r]);
        @(negedge clk);
      end
      cfg_we <= 1'b0;

      calm_in  = (p == 3);
      calm_out = (p == 6);
      // long receiver hold-off while the sender keeps offering words
      if (p == 1 || p == 5)
        hold_req = 1'b1;
      random_traffic(PHASE_WORDS);
    end

    drain();
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
